FILE: rtl/core/lpto_pkg.sv
package lpto_pkg;
    localparam int MAX_TASKS_DEF = 64;
    localparam int TIME_W = 11;
    localparam int IDX_W = 6;
endpackage

FILE: rtl/core/lpto_ram.sv
module lpto_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/lifo_preemptive_task_order.sv
// LIFO preemptive task order.
// Input channel s_axis: one request per task. s_axis_tdata holds start_minute
// in bits 10:0 and duration in bits 21:11; s_axis_tlast marks the last task.
// Output channel m_axis: one request per completed task. m_axis_tdata holds
// the 6-bit arrival index; m_axis_tlast marks the final completion.
// Loading accepts one task per cycle. After the last task the block runs a
// stable insertion sort in memory by start minute, then simulates execution
// task by task, pushing a preempted task on the stack and popping stacked
// tasks as time allows; each completion passes through the output register.
// Each step waits on the registered memory read.
// Each completion waits in the output register until taken; a stall on the
// output simply holds the sequencer. No new task is accepted until the run
// is finished and the last completion is taken.
// Reset clears the sequencer, the task count and the stack depth; the
// memories are not cleared, since only entries written in the current set
// are ever read.
module lifo_preemptive_task_order #(
    parameter int MAX_TASKS = lpto_pkg::MAX_TASKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // start_minute[10:0], duration[21:11]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // task_index[5:0]
    output logic        m_axis_tlast
);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = lpto_pkg::TIME_W;
    localparam int IW = lpto_pkg::IDX_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    localparam logic [4:0] S_LOAD = 5'd0,  S_SI = 5'd1,  S_SA = 5'd2,
                           S_SB = 5'd3,  S_SC = 5'd4,  S_SD = 5'd5,
                           S_SE = 5'd6,  S_R0 = 5'd7,  S_R1 = 5'd8,
                           S_R2 = 5'd9,  S_T0 = 5'd10, S_T1 = 5'd11,
                           S_T2 = 5'd12, S_P0 = 5'd13, S_P1 = 5'd14,
                           S_P2 = 5'd15, S_L0 = 5'd16, S_L1 = 5'd17,
                           S_F0 = 5'd18, S_F1 = 5'd19, S_OUT = 5'd20,
                           S_SF = 5'd21;

    logic [4:0]    state_reg;
    logic [4:0]    ret_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [AW-1:0] key_reg;
    logic [TW-1:0] keyst_reg;
    logic [AW-1:0] t_reg;
    logic [AW-1:0] p_reg;
    logic [TW:0]   time_reg;
    logic [TW:0]   next_reg;
    logic [IW-1:0] oidx_reg;
    logic          olast_reg;
    logic          ovalid_reg;

    logic          st_we, rm_we, so_we, ps_we;
    logic [AW-1:0] st_wa, rm_wa, so_wa, ps_wa;
    logic [AW-1:0] st_ra, rm_ra, so_ra, ps_ra;
    logic [TW-1:0] st_wd, rm_wd, st_rd, rm_rd;
    logic [AW-1:0] so_wd, ps_wd, so_rd, ps_rd;

    lpto_ram #(.DEPTH(MAX_TASKS), .WIDTH(TW)) u_start (
        .aclk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
    lpto_ram #(.DEPTH(MAX_TASKS), .WIDTH(TW)) u_rem (
        .aclk, .we(rm_we), .waddr(rm_wa), .wdata(rm_wd), .raddr(rm_ra), .rdata(rm_rd));
    lpto_ram #(.DEPTH(MAX_TASKS), .WIDTH(AW)) u_order (
        .aclk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
    lpto_ram #(.DEPTH(MAX_TASKS), .WIDTH(AW)) u_stack (
        .aclk, .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, oidx_reg};
    assign m_axis_tlast  = olast_reg;

    logic          s_acc;
    logic [TW:0]   gap;
    logic [TW:0]   rem_ext;
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign rem_ext = {1'b0, rm_rd};
    assign gap     = next_reg - time_reg;

    // Memory ports are driven combinationally from the state; reads land
    // in the following cycle.
    always_comb begin
        st_we = 1'b0; st_wa = count_reg[AW-1:0]; st_wd = s_axis_tdata[TW-1:0];
        rm_we = 1'b0; rm_wa = t_reg; rm_wd = rm_rd - gap[TW-1:0];
        so_we = 1'b0; so_wa = i_reg[AW-1:0]; so_wd = i_reg[AW-1:0];
        ps_we = 1'b0; ps_wa = depth_reg[AW-1:0]; ps_wd = t_reg;
        st_ra = so_rd; rm_ra = t_reg; so_ra = i_reg[AW-1:0];
        ps_ra = AW'(depth_reg - CW'(1));
        unique case (state_reg)
            S_LOAD: begin
                st_we = s_acc && (count_reg < FULL);
                rm_we = st_we;
                rm_wa = count_reg[AW-1:0];
                rm_wd = s_axis_tdata[2*TW-1:TW];
            end
            S_SI: so_we = 1'b1;
            S_SA: so_ra = i_reg[AW-1:0];
            S_SB: st_ra = so_rd;
            S_SC: so_ra = AW'(j_reg - CW'(1));
            S_SD: begin
                st_ra = so_rd;
                so_ra = AW'(j_reg - CW'(1));
            end
            S_SE: begin
                so_wa = j_reg[AW-1:0];
                if (j_reg != '0 && st_rd > keyst_reg) begin
                    so_we = 1'b1; so_wd = so_rd;
                end else begin
                    so_we = 1'b1; so_wd = key_reg;
                end
            end
            S_SF: ;
            S_R0: so_ra = '0;
            S_R1: st_ra = so_rd;
            S_R2: ;
            S_T0: so_ra = AW'(i_reg + CW'(1));
            S_T1: begin st_ra = so_rd; rm_ra = t_reg; end
            S_T2: begin
                if (gap < rem_ext) begin
                    rm_we = 1'b1; rm_wa = t_reg;
                    ps_we = (depth_reg < FULL);
                end
            end
            S_P0: ;
            S_P1: rm_ra = ps_rd;
            S_P2: begin
                if (gap < rem_ext) begin
                    rm_we = 1'b1; rm_wa = p_reg;
                end
            end
            S_L0: so_ra = i_reg[AW-1:0];
            S_L1: ;
            S_F0: ;
            S_F1: so_ra = AW'(i_reg + CW'(1));
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            depth_reg  <= '0;
            ovalid_reg <= 1'b0;
            ret_reg    <= S_LOAD;
        end else begin
            unique case (state_reg)
                S_LOAD: if (s_acc) begin
                    if (count_reg < FULL) count_reg <= count_reg + CW'(1);
                    if (s_axis_tlast) begin
                        i_reg <= '0;
                        state_reg <= S_SI;
                    end
                end
                S_SI: begin
                    if (i_reg + CW'(1) >= count_reg) begin
                        i_reg <= CW'(1);
                        state_reg <= S_SA;
                    end else begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_SA: state_reg <= (i_reg >= count_reg) ? S_R0 : S_SB;
                S_SB: begin
                    key_reg <= so_rd;
                    j_reg <= i_reg;
                    state_reg <= S_SF;
                end
                S_SF: begin
                    keyst_reg <= st_rd;
                    state_reg <= S_SC;
                end
                S_SC: state_reg <= S_SD;
                S_SD: state_reg <= S_SE;
                S_SE: begin
                    if (j_reg != '0 && st_rd > keyst_reg) begin
                        j_reg <= j_reg - CW'(1);
                        state_reg <= S_SC;
                    end else begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_SA;
                    end
                end
                S_R0: begin i_reg <= '0; depth_reg <= '0; state_reg <= S_R1; end
                S_R1: state_reg <= S_R2;
                S_R2: begin
                    time_reg <= {1'b0, st_rd};
                    state_reg <= (count_reg <= CW'(1)) ? S_L0 : S_T0;
                end
                S_T0: begin t_reg <= so_rd; state_reg <= S_T1; end
                S_T1: state_reg <= S_F0;
                S_F0: begin next_reg <= {1'b0, st_rd}; state_reg <= S_T2; end
                S_T2: begin
                    if (gap >= rem_ext) begin
                        time_reg <= time_reg + rem_ext;
                        oidx_reg <= IW'(t_reg);
                        olast_reg <= 1'b0;
                        ovalid_reg <= 1'b1;
                        ret_reg <= S_P0;
                        state_reg <= S_OUT;
                    end else begin
                        if (depth_reg < FULL) depth_reg <= depth_reg + CW'(1);
                        state_reg <= S_F1;
                    end
                end
                S_P0: state_reg <= (depth_reg == '0) ? S_F1 : S_P1;
                S_P1: begin p_reg <= ps_rd; state_reg <= S_P2; end
                S_P2: begin
                    if (gap >= rem_ext) begin
                        time_reg <= time_reg + rem_ext;
                        depth_reg <= depth_reg - CW'(1);
                        oidx_reg <= IW'(p_reg);
                        olast_reg <= 1'b0;
                        ovalid_reg <= 1'b1;
                        ret_reg <= S_P0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_F1;
                    end
                end
                S_F1: begin
                    time_reg <= next_reg;
                    i_reg <= i_reg + CW'(1);
                    state_reg <= (i_reg + CW'(2) < count_reg) ? S_T0 : S_L0;
                end
                S_L0: state_reg <= S_L1;
                S_L1: begin
                    // Final task of the order, then the stack drains from the top.
                    if (i_reg < count_reg) begin
                        oidx_reg <= IW'(so_rd);
                        i_reg <= count_reg;
                    end else begin
                        oidx_reg <= IW'(ps_rd);
                        depth_reg <= depth_reg - CW'(1);
                    end
                    olast_reg <= (i_reg < count_reg) ? (depth_reg == '0)
                                                     : (depth_reg == CW'(1));
                    ovalid_reg <= 1'b1;
                    ret_reg <= S_L0;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    ovalid_reg <= 1'b0;
                    if (olast_reg) begin
                        count_reg <= '0;
                        depth_reg <= '0;
                        state_reg <= S_LOAD;
                    end else begin
                        state_reg <= ret_reg;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule
